>>> rtl/pwmwx_pkg.sv
// Package for the chip-stream weather packet decoder.
// Holds sizes, header and check constants, the result record and helper functions.
// No dependencies.
package pwmwx_pkg;

  localparam int PACKET_BYTES  = 17;
  localparam int CHIPS_PER_BIT = 7;
  localparam int PACKET_BITS   = PACKET_BYTES * 8;
  localparam int PACKET_CHIPS  = PACKET_BITS * CHIPS_PER_BIT;
  localparam int FIELD_BYTES   = 32;
  localparam int ROW_CNT_W     = $clog2(PACKET_CHIPS + 1);
  localparam int ONES_W        = 4;   // covers counts up to 15 chips per bit
  localparam int THR_W         = 3;

  localparam logic [THR_W-1:0] THR_RESET  = 3'd4;
  localparam logic [7:0]       GF_MULT    = 8'h83;
  localparam logic [7:0]       CK_SEED    = 8'h2D;
  localparam logic [7:0]       HDR_BYTE0  = 8'hF0;
  localparam logic [3:0]       HDR_NIBBLE = 4'h5;
  localparam logic [7:0]       SUM_OK     = 8'hFF;
  localparam logic [11:0]      GUST_RSVD  = 12'h0C00;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic        check_status;
    logic [23:0] device_id;
    logic [2:0]  repeat_counter;
    logic        battery_ok;
    logic [11:0] temperature_tenths;
    logic [7:0]  humidity;
    logic [11:0] wind_average;
    logic [11:0] wind_gust;
    logic [3:0]  wind_direction;
    logic [11:0] rain_tips;
    logic        reserved_nonzero;
  } pwmwx_result_t;

  // low byte of the carry-less product with GF_MULT
  function automatic byte_t gf2_map(input byte_t x);
    byte_t acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) begin
        acc = acc ^ byte_t'(GF_MULT << i);
      end
    end
    return acc;
  endfunction

  function automatic logic [ONES_W-1:0] ones_count(input logic [CHIPS_PER_BIT-1:0] g);
    logic [ONES_W-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < CHIPS_PER_BIT; k++) begin
      cnt = cnt + ONES_W'(g[k]);
    end
    return cnt;
  endfunction

endpackage

>>> rtl/pwmwx_if.sv
// Valid/ready channel interfaces for the weather packet decoder.
// No dependencies.
interface pwmwx_in_if;
  logic valid;
  logic ready;
  logic chip;
  logic row_start;
  modport source (output valid, output chip, output row_start, input ready);
  modport sink   (input valid, input chip, input row_start, output ready);
endinterface

interface pwmwx_out_if;
  logic               valid;
  logic               ready;
  logic               check_status;
  logic [23:0]        device_id;
  logic [2:0]         repeat_counter;
  logic               battery_ok;
  logic signed [11:0] temperature_tenths;
  logic [7:0]         humidity;
  logic [11:0]        wind_average;
  logic [11:0]        wind_gust;
  logic [3:0]         wind_direction;
  logic [11:0]        rain_tips;
  logic               reserved_nonzero;
  modport source (output valid, output check_status, output device_id,
                  output repeat_counter, output battery_ok, output temperature_tenths,
                  output humidity, output wind_average, output wind_gust,
                  output wind_direction, output rain_tips, output reserved_nonzero,
                  input ready);
  modport sink   (input valid, input check_status, input device_id,
                  input repeat_counter, input battery_ok, input temperature_tenths,
                  input humidity, input wind_average, input wind_gust,
                  input wind_direction, input rain_tips, input reserved_nonzero,
                  output ready);
endinterface

interface pwmwx_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] ones_threshold;
  modport source (output valid, output ones_threshold, input ready);
  modport sink   (input valid, input ones_threshold, output ready);
endinterface

>>> rtl/pwm_chip_weather_packet_decoder_top.sv
// A completing chip is held in the window stage, then its result in the result register.
// Throughput: one chip per cycle; the window register and the result register stall only
// while a result waits on out_ch.ready with another chip already held in the window stage.
// Reset (rst_n low, synchronous): clears row fill, suppression count, pending flags and
// sets ones_threshold to 4. Window chips are not cleared; a full row refills them.
module pwm_chip_weather_packet_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  pwmwx_in_if.sink    in_ch,
  pwmwx_out_if.source out_ch,
  pwmwx_cfg_if.sink   cfg_ch
);
  import pwmwx_pkg::*;

  logic [PACKET_CHIPS-1:0] window_r, window_nxt;   // bit 0 is the oldest chip
  logic                    pend_r, pend_nxt;
  logic                    full_r, full_nxt;
  logic [ROW_CNT_W-1:0]    row_cnt_r, row_cnt_nxt, row_base;
  logic [ROW_CNT_W-1:0]    skip_r, skip_nxt;
  logic [THR_W-1:0]        thr_r, thr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pwmwx_result_t           res_r, res_nxt;

  logic in_xfer, adv, eval, emit, hdr_ok, pkt_ok;
  logic [PACKET_BITS-1:0] bits;
  byte_t                  fb [FIELD_BYTES];
  byte_t                  ck, xk, csum, ck_plus;
  logic [11:0]            gust;

  assign adv       = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || adv;
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // slice the window into bits, oldest group first
  always_comb begin
    for (int i = 0; i < PACKET_BITS; i++) begin
      bits[i] = ones_count(window_r[i*CHIPS_PER_BIT +: CHIPS_PER_BIT]) >= ONES_W'(thr_r);
    end
    for (int k = 0; k < FIELD_BYTES; k++) begin
      fb[k] = '0;
      if (k < PACKET_BYTES) begin
        for (int j = 0; j < 8; j++) begin
          fb[k][7-j] = bits[k*8 + j];
        end
      end
    end
  end

  always_comb begin
    csum = CK_SEED;
    for (int i = 0; i < PACKET_BYTES - 2; i++) begin
      csum = csum ^ gf2_map(fb[i]);
    end
  end

  assign ck      = fb[PACKET_BYTES-2];
  assign xk      = fb[PACKET_BYTES-1];
  assign ck_plus = ck + xk;
  assign hdr_ok  = (fb[0] == HDR_BYTE0) && (fb[1][7:4] == HDR_NIBBLE);
  assign pkt_ok  = (ck_plus == SUM_OK) && (ck == csum);
  assign eval    = adv && full_r && (skip_r == '0);
  assign emit    = eval && hdr_ok;
  assign gust    = {fb[9][3:0], fb[10]};

  always_comb begin
    res_nxt.check_status       = !pkt_ok;
    res_nxt.device_id          = {fb[2], fb[3], fb[4]};
    res_nxt.repeat_counter     = fb[1][2:0];
    res_nxt.battery_ok         = fb[5][4];
    res_nxt.temperature_tenths = {fb[5][3:0], fb[6]};
    res_nxt.humidity           = fb[7];
    res_nxt.wind_average       = {fb[8], fb[9][7:4]};
    res_nxt.wind_gust          = gust;
    res_nxt.wind_direction     = fb[11][7:4];
    res_nxt.rain_tips          = {fb[11][3:0], fb[12]};
    res_nxt.reserved_nonzero   = ((gust & GUST_RSVD) != '0) || (fb[13] != '0)
                                 || (fb[14] != '0);
  end

  always_comb begin
    window_nxt  = window_r;
    pend_nxt    = pend_r;
    full_nxt    = full_r;
    row_cnt_nxt = row_cnt_r;
    skip_nxt    = skip_r;
    thr_nxt     = thr_r;
    out_valid_nxt = out_valid_r;

    if (adv) begin
      pend_nxt = 1'b0;
    end
    // the item leaving the window stage settles suppression first
    if (adv && full_r) begin
      if (skip_r != '0) begin
        skip_nxt = skip_r - 1'b1;
      end else if (hdr_ok && pkt_ok) begin
        skip_nxt = ROW_CNT_W'(PACKET_CHIPS);
      end
    end
    if (in_xfer) begin
      pend_nxt   = 1'b1;
      window_nxt = {in_ch.chip, window_r[PACKET_CHIPS-1:1]};
      row_base   = in_ch.row_start ? '0 : row_cnt_r;
      if (row_base < ROW_CNT_W'(PACKET_CHIPS)) begin
        row_cnt_nxt = row_base + 1'b1;
      end else begin
        row_cnt_nxt = row_base;
      end
      full_nxt = (row_cnt_nxt == ROW_CNT_W'(PACKET_CHIPS));
      if (in_ch.row_start) begin
        skip_nxt = '0;
      end
    end else begin
      row_base = row_cnt_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      thr_nxt = cfg_ch.ones_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      full_r      <= 1'b0;
      row_cnt_r   <= '0;
      skip_r      <= '0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      full_r      <= full_nxt;
      row_cnt_r   <= row_cnt_nxt;
      skip_r      <= skip_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    window_r <= window_nxt;
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.check_status       = res_r.check_status;
  assign out_ch.device_id          = res_r.device_id;
  assign out_ch.repeat_counter     = res_r.repeat_counter;
  assign out_ch.battery_ok         = res_r.battery_ok;
  assign out_ch.temperature_tenths = $signed(res_r.temperature_tenths);
  assign out_ch.humidity           = res_r.humidity;
  assign out_ch.wind_average       = res_r.wind_average;
  assign out_ch.wind_gust          = res_r.wind_gust;
  assign out_ch.wind_direction     = res_r.wind_direction;
  assign out_ch.rain_tips          = res_r.rain_tips;
  assign out_ch.reserved_nonzero   = res_r.reserved_nonzero;

endmodule

>>> rtl/pwmwx_checker.sv
// Port-level checker for the weather packet decoder, bound to the top level.
// Depends on pwmwx_if and pwm_chip_weather_packet_decoder_top (through the bind).
module pwmwx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_device_id,
  input logic        out_check_status
);

  // result held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_device_id) && $stable(out_check_status))
    else $error("result payload changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with no result waiting the window stage can always drain
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind pwm_chip_weather_packet_decoder_top pwmwx_checker u_pwmwx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_device_id    (out_ch.device_id),
  .out_check_status (out_ch.check_status)
);
